// ===== design/adse_pkg.sv =====
// ----------------------------------------------------------------------------
// adse_pkg
// Types, constants and mark-coding functions for the Arabic diacritic
// stripper and encoder core.
// ----------------------------------------------------------------------------
package adse_pkg;

    localparam int unsigned CpWidth   = 21;
    localparam int unsigned CodeWidth = 4;

    localparam logic [CpWidth-1:0] MarkLo         = 21'h00064B;
    localparam logic [CpWidth-1:0] MarkHi         = 21'h000652;
    localparam logic [CpWidth-1:0] MarkSuperAlef  = 21'h000670;
    localparam logic [CpWidth-1:0] MarkShadda     = 21'h000651;

    localparam logic [CodeWidth-1:0] CodeNone           = 4'd0;
    localparam logic [CodeWidth-1:0] CodeFatha          = 4'd1;
    localparam logic [CodeWidth-1:0] CodeDamma          = 4'd2;
    localparam logic [CodeWidth-1:0] CodeKasra          = 4'd3;
    localparam logic [CodeWidth-1:0] CodeSukun          = 4'd4;
    localparam logic [CodeWidth-1:0] CodeShadda         = 4'd5;
    localparam logic [CodeWidth-1:0] CodeFathatan       = 4'd6;
    localparam logic [CodeWidth-1:0] CodeDammatan       = 4'd7;
    localparam logic [CodeWidth-1:0] CodeKasratan       = 4'd8;
    localparam logic [CodeWidth-1:0] CodeShaddaFatha    = 4'd9;
    localparam logic [CodeWidth-1:0] CodeShaddaDamma    = 4'd10;
    localparam logic [CodeWidth-1:0] CodeShaddaKasra    = 4'd11;
    localparam logic [CodeWidth-1:0] CodeShaddaFathatan = 4'd12;
    localparam logic [CodeWidth-1:0] CodeShaddaDammatan = 4'd13;
    localparam logic [CodeWidth-1:0] CodeShaddaKasratan = 4'd14;

    typedef struct packed {
        logic [CpWidth-1:0] codepoint;
        logic               text_end;
    } t_in_req;

    typedef struct packed {
        logic [CpWidth-1:0]   base_codepoint;
        logic [CodeWidth-1:0] mark_code;
        logic                 final_item;
    } t_out_req;

    // Mark type for the low three bits of a codepoint offset from MarkLo.
    function automatic logic [CodeWidth-1:0] mark_type(input logic [2:0] offset);
        logic [CodeWidth-1:0] result;
        case (offset)
            3'd0:    result = CodeFathatan;
            3'd1:    result = CodeDammatan;
            3'd2:    result = CodeKasratan;
            3'd3:    result = CodeFatha;
            3'd4:    result = CodeDamma;
            3'd5:    result = CodeKasra;
            3'd6:    result = CodeShadda;
            default: result = CodeSukun;
        endcase
        return result;
    endfunction

    function automatic logic [CodeWidth-1:0] mark_code(
        input logic [CodeWidth-1:0] prim,
        input logic                 shadda
    );
        logic [CodeWidth-1:0] result;
        if (!shadda) begin
            result = prim;
        end else begin
            case (prim)
                CodeFatha:    result = CodeShaddaFatha;
                CodeDamma:    result = CodeShaddaDamma;
                CodeKasra:    result = CodeShaddaKasra;
                CodeFathatan: result = CodeShaddaFathatan;
                CodeDammatan: result = CodeShaddaDammatan;
                CodeKasratan: result = CodeShaddaKasratan;
                default:      result = CodeShadda;
            endcase
        end
        return result;
    endfunction

endpackage

// ===== design/arabic_diacritic_stripper_encoder_core.sv =====
// ----------------------------------------------------------------------------
// arabic_diacritic_stripper_encoder_core
// Strips Arabic diacritic marks from a codepoint stream and emits each base
// character with a 4-bit code of its marks.
// ----------------------------------------------------------------------------
//
//  channel  valid    ready    request   direction
//  input    i_valid  o_ready  i_req     codepoint, text_end in
//  output   o_valid  i_ready  o_req     base, mark code, final flag out
//
// One codepoint is accepted per cycle while o_ready is high. Results go
// into a three-entry output queue; with the queue empty, a result is
// registered there and appears in the cycle after its codepoint. o_ready
// is high while the queue holds at most one request, so an item that
// flushes two results always stalls input until the queue drains to one.
// Reset is synchronous and active low; it clears the pending base and queue.
// ----------------------------------------------------------------------------
module arabic_diacritic_stripper_encoder_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  adse_pkg::t_in_req i_req,
    output logic              o_valid,
    input  logic              i_ready,
    output adse_pkg::t_out_req o_req
);

    logic                              r_pend_valid;
    logic [adse_pkg::CpWidth-1:0]      r_pend_base;
    logic [adse_pkg::CodeWidth-1:0]    r_prim;
    logic                              r_shadda;
    adse_pkg::t_out_req                r_q [3];
    logic [1:0]                        r_cnt;

    logic                              n_pend_valid;
    logic [adse_pkg::CpWidth-1:0]      n_pend_base;
    logic [adse_pkg::CodeWidth-1:0]    n_prim;
    logic                              n_shadda;
    adse_pkg::t_out_req                n_q [3];
    logic [1:0]                        n_cnt;

    logic                              acc;
    logic                              pop;
    logic                              is_mark;
    logic [2:0]                        cp_off;
    logic [adse_pkg::CodeWidth-1:0]    upd_prim;
    logic                              upd_shadda;
    adse_pkg::t_out_req                res0;
    adse_pkg::t_out_req                res1;
    logic [1:0]                        n_res;
    logic [1:0]                        cnt_p;

    assign o_ready = (r_cnt <= 2'd1);
    assign acc     = i_valid && o_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign o_req   = r_q[0];
    assign pop     = o_valid && i_ready;

    assign is_mark = ((i_req.codepoint >= adse_pkg::MarkLo) &&
                      (i_req.codepoint <= adse_pkg::MarkHi)) ||
                     (i_req.codepoint == adse_pkg::MarkSuperAlef);
    assign cp_off  = i_req.codepoint[2:0] - adse_pkg::MarkLo[2:0];

    always_comb begin
        upd_prim   = r_prim;
        upd_shadda = r_shadda;
        if (r_pend_valid) begin
            if (i_req.codepoint == adse_pkg::MarkShadda) begin
                upd_shadda = 1'b1;
            end else if (i_req.codepoint == adse_pkg::MarkSuperAlef) begin
                upd_prim = r_prim;
            end else if (r_prim == adse_pkg::CodeNone) begin
                upd_prim = adse_pkg::mark_type(cp_off);
            end
        end
    end

    always_comb begin
        res0         = '{base_codepoint: r_pend_base,
                         mark_code: adse_pkg::mark_code(r_prim, r_shadda),
                         final_item: 1'b0};
        res1         = '{base_codepoint: i_req.codepoint,
                         mark_code: adse_pkg::CodeNone,
                         final_item: 1'b1};
        n_res        = 2'd0;
        n_pend_valid = r_pend_valid;
        n_pend_base  = r_pend_base;
        n_prim       = r_prim;
        n_shadda     = r_shadda;
        if (acc) begin
            if (is_mark) begin
                n_prim   = upd_prim;
                n_shadda = upd_shadda;
                if (i_req.text_end && r_pend_valid) begin
                    res0.mark_code  = adse_pkg::mark_code(upd_prim, upd_shadda);
                    res0.final_item = 1'b1;
                    n_res           = 2'd1;
                end
            end else begin
                n_pend_valid = 1'b1;
                n_pend_base  = i_req.codepoint;
                n_prim       = adse_pkg::CodeNone;
                n_shadda     = 1'b0;
                if (r_pend_valid) begin
                    n_res = i_req.text_end ? 2'd2 : 2'd1;
                end else if (i_req.text_end) begin
                    res0  = res1;
                    n_res = 2'd1;
                end
            end
            if (i_req.text_end) begin
                n_pend_valid = 1'b0;
                n_pend_base  = '0;
                n_prim       = adse_pkg::CodeNone;
                n_shadda     = 1'b0;
            end
        end
    end

    always_comb begin
        n_q   = r_q;
        cnt_p = r_cnt;
        if (pop) begin
            n_q[0] = r_q[1];
            n_q[1] = r_q[2];
            cnt_p  = r_cnt - 2'd1;
        end
        for (int j = 0; j < 3; j++) begin
            if ((n_res != 2'd0) && (cnt_p == 2'(j))) begin
                n_q[j] = res0;
            end
            if ((n_res == 2'd2) && ((cnt_p + 2'd1) == 2'(j))) begin
                n_q[j] = res1;
            end
        end
        n_cnt = cnt_p + n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_pend_base  <= '0;
            r_prim       <= adse_pkg::CodeNone;
            r_shadda     <= 1'b0;
            r_cnt        <= 2'd0;
        end else begin
            r_pend_valid <= n_pend_valid;
            r_pend_base  <= n_pend_base;
            r_prim       <= n_prim;
            r_shadda     <= n_shadda;
            r_cnt        <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_req.text_end) |=> !r_pend_valid)
        else $error("pending base survived the end of a text");

    a_base_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !is_mark && !i_req.text_end)
            |=> (r_pend_valid && (r_pend_base == $past(i_req.codepoint))))
        else $error("base character was not loaded as pending");

    a_idle_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_pend_valid |-> ((r_prim == adse_pkg::CodeNone) && !r_shadda))
        else $error("marks held without a pending base");

    a_flush_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !is_mark && r_pend_valid) |=> (r_cnt != 2'd0))
        else $error("flushed base character missing from the queue");

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Arabic diacritic stripper and encoder core.
// A scoreboard tracks the pending base character and its marks, predicts
// every emitted request, and compares the core's output field by field,
// while directed and random streams run, mostly under random back-pressure.
// ----------------------------------------------------------------------------
module tb;

    localparam int TotalItems = 2000;
    localparam int CalmItems  = 300;
    localparam int HoldCycles = 300;
    localparam int CycleLimit = 500000;
    localparam int CpW        = adse_pkg::CpWidth;

    class mark_scoreboard;
        adse_pkg::t_out_req                expected_q[$];
        logic                              base_held;
        logic [adse_pkg::CpWidth-1:0]      held_base;
        logic [adse_pkg::CodeWidth-1:0]    first_mark;
        logic                              shadda_on;
        logic [adse_pkg::CodeWidth-1:0]    kind_by_offset[8];
        int                                errors;

        function new();
            kind_by_offset = '{adse_pkg::CodeFathatan, adse_pkg::CodeDammatan,
                               adse_pkg::CodeKasratan, adse_pkg::CodeFatha,
                               adse_pkg::CodeDamma, adse_pkg::CodeKasra,
                               adse_pkg::CodeShadda, adse_pkg::CodeSukun};
            errors = 0;
            clear_text();
        endfunction

        function void clear_text();
            base_held  = 1'b0;
            held_base  = '0;
            first_mark = adse_pkg::CodeNone;
            shadda_on  = 1'b0;
        endfunction

        function logic [adse_pkg::CodeWidth-1:0] combined_code();
            if (!shadda_on) begin
                return first_mark;
            end
            case (first_mark)
                adse_pkg::CodeFatha:    return adse_pkg::CodeShaddaFatha;
                adse_pkg::CodeDamma:    return adse_pkg::CodeShaddaDamma;
                adse_pkg::CodeKasra:    return adse_pkg::CodeShaddaKasra;
                adse_pkg::CodeFathatan: return adse_pkg::CodeShaddaFathatan;
                adse_pkg::CodeDammatan: return adse_pkg::CodeShaddaDammatan;
                adse_pkg::CodeKasratan: return adse_pkg::CodeShaddaKasratan;
                default:                return adse_pkg::CodeShadda;
            endcase
        endfunction

        function void push_base(logic last);
            adse_pkg::t_out_req e;
            e.base_codepoint = held_base;
            e.mark_code      = combined_code();
            e.final_item     = last;
            expected_q       = {expected_q, e};
        endfunction

        function void note_request(adse_pkg::t_in_req r);
            logic                         is_mark;
            logic [adse_pkg::CpWidth-1:0] offset;
            is_mark = (r.codepoint >= adse_pkg::MarkLo && r.codepoint <= adse_pkg::MarkHi)
                      || r.codepoint == adse_pkg::MarkSuperAlef;
            offset  = r.codepoint - adse_pkg::MarkLo;
            if (is_mark) begin
                if (base_held) begin
                    if (r.codepoint == adse_pkg::MarkShadda) begin
                        shadda_on = 1'b1;
                    end else if (r.codepoint != adse_pkg::MarkSuperAlef &&
                                 first_mark == adse_pkg::CodeNone) begin
                        first_mark = kind_by_offset[offset[2:0]];
                    end
                end
            end else begin
                if (base_held) begin
                    push_base(1'b0);
                end
                held_base  = r.codepoint;
                first_mark = adse_pkg::CodeNone;
                shadda_on  = 1'b0;
                base_held  = 1'b1;
            end
            if (r.text_end) begin
                if (base_held) begin
                    push_base(1'b1);
                end
                clear_text();
            end
        endfunction

        function void check_result(adse_pkg::t_out_req r);
            adse_pkg::t_out_req e;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected request base %h code %0d final %b",
                         $time, r.base_codepoint, r.mark_code, r.final_item);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (r.base_codepoint !== e.base_codepoint) begin
                $display("%0t: base_codepoint expected %h actual %h",
                         $time, e.base_codepoint, r.base_codepoint);
                errors++;
            end
            if (r.mark_code !== e.mark_code) begin
                $display("%0t: mark_code expected %0d actual %0d",
                         $time, e.mark_code, r.mark_code);
                errors++;
            end
            if (r.final_item !== e.final_item) begin
                $display("%0t: final_item expected %b actual %b",
                         $time, e.final_item, r.final_item);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    adse_pkg::t_in_req  i_req;
    logic               o_valid;
    logic               i_ready;
    adse_pkg::t_out_req o_req;

    mark_scoreboard sb = new();
    int   items_sent = 0;
    int   cycles     = 0;
    int   send_rate  = 0;
    logic calm       = 1'b0;
    logic held_off   = 1'b0;

    arabic_diacritic_stripper_encoder_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_req   (o_req)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #4 i_clk = ~i_clk;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                sb.check_result(o_req);
            end
            if (i_valid && o_ready) begin
                sb.note_request(i_req);
            end
        end
    end

    initial begin : receiver
        int tick;
        int rate;
        tick    = 0;
        rate    = 0;
        i_ready = 1'b0;
        @(negedge i_clk);
        while (!i_rst_n) begin
            @(negedge i_clk);
        end
        forever begin
            if (!held_off && items_sent >= 500) begin
                held_off = 1'b1;
                i_ready  = 1'b0;
                repeat (HoldCycles) @(negedge i_clk);
            end
            if (tick % 64 == 0) begin
                rate = $urandom_range(0, 3);
            end
            tick++;
            if (!calm && rate != 0 && $urandom_range(0, 15) < rate) begin
                i_ready = 1'b0;
                repeat ($urandom_range(1, 15) - 1) @(negedge i_clk);
            end else begin
                i_ready = 1'b1;
            end
            @(negedge i_clk);
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input logic [adse_pkg::CpWidth-1:0] cp, input logic last);
        if (items_sent % 64 == 0) begin
            send_rate = $urandom_range(0, 3);
        end
        if (!calm && send_rate != 0 && $urandom_range(0, 15) < send_rate) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_req   = '{codepoint: cp, text_end: last};
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        items_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [adse_pkg::CpWidth-1:0] pick_mark();
        int idx;
        idx = $urandom_range(0, 8);
        if (idx == 8) begin
            return adse_pkg::MarkSuperAlef;
        end
        return adse_pkg::MarkLo + CpW'(idx);
    endfunction

    function automatic logic [adse_pkg::CpWidth-1:0] pick_base();
        case ($urandom_range(0, 5))
            0:       return CpW'($urandom_range(0, 21'h1FFFFF));
            1:       return CpW'($urandom_range(21'h000640, 21'h000680));
            default: return CpW'($urandom_range(21'h000621, 21'h00064A));
        endcase
    endfunction

    task automatic send_word();
        int n_marks;
        n_marks = $urandom_range(0, 3);
        if ($urandom_range(0, 9) != 0) begin
            send_item(pick_base(), $urandom_range(0, 11) == 0);
        end
        repeat (n_marks) begin
            send_item(pick_mark(), $urandom_range(0, 11) == 0);
        end
    endtask

    initial begin : stimulus
        adse_pkg::t_in_req directed[$];
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_req   = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        directed = '{
            '{21'h00064E, 1'b0}, '{adse_pkg::MarkShadda, 1'b0}, '{21'h000000, 1'b0},
            '{21'h00064B, 1'b0}, '{21'h00064E, 1'b0}, '{21'h00064A, 1'b0},
            '{adse_pkg::MarkShadda, 1'b0}, '{21'h00064D, 1'b0}, '{21'h000653, 1'b0},
            '{adse_pkg::MarkHi, 1'b0}, '{adse_pkg::MarkShadda, 1'b0},
            '{21'h00066F, 1'b0}, '{adse_pkg::MarkSuperAlef, 1'b0},
            '{adse_pkg::MarkShadda, 1'b0}, '{21'h000671, 1'b0},
            '{21'h00064C, 1'b0}, '{21'h1FFFFF, 1'b0}, '{21'h00064F, 1'b0},
            '{21'h110000, 1'b0}, '{21'h000650, 1'b1}, '{adse_pkg::MarkShadda, 1'b1},
            '{21'h10FFFF, 1'b0}, '{21'h000628, 1'b1}, '{21'h000621, 1'b1}
        };
        foreach (directed[i]) begin
            send_item(directed[i].codepoint, directed[i].text_end);
        end

        while (items_sent < TotalItems) begin
            if (items_sent >= TotalItems - CalmItems) begin
                calm = 1'b1;
            end
            send_word();
        end
        send_item(pick_base(), 1'b1);
        i_valid = 1'b0;

        while (sb.expected_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
